// File: sv/geeh_pkg.sv
package geeh_pkg;

   localparam int NodeBits = 15;
   localparam int NodeW = NodeBits + 1;
   localparam int EdgeW = 15;
   localparam int NonceW = EdgeW + 1;
   localparam int OutW = 16;
   localparam int Rounds = 6;
   localparam int InjectAfter = 1;
   localparam int CsrIndexW = 8;

   localparam logic [CsrIndexW-1:0] CsrKey0 = 8'd0;
   localparam logic [CsrIndexW-1:0] CsrKey1 = 8'd1;
   localparam logic [CsrIndexW-1:0] CsrKey2 = 8'd2;
   localparam logic [CsrIndexW-1:0] CsrKey3 = 8'd3;

   localparam logic [63:0] FinalConst = 64'h0000_0000_0000_00ff;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } sip_state_type;

   typedef logic [Rounds-1:0] stage_en_type;

   function automatic sip_state_type mix_round(input sip_state_type s);
      sip_state_type r;
      r = s;
      r.a = r.a + r.b;
      r.c = r.c + r.d;
      r.b = (r.b << 13) | (r.b >> 51);
      r.d = (r.d << 16) | (r.d >> 48);
      r.b = r.b ^ r.a;
      r.d = r.d ^ r.c;
      r.a = (r.a << 32) | (r.a >> 32);
      r.c = r.c + r.b;
      r.a = r.a + r.d;
      r.b = (r.b << 17) | (r.b >> 47);
      r.d = (r.d << 21) | (r.d >> 43);
      r.b = r.b ^ r.c;
      r.d = r.d ^ r.a;
      r.c = (r.c << 32) | (r.c >> 32);
      return r;
   endfunction

   function automatic logic [OutW-1:0] node_id(input sip_state_type s, input logic side);
      logic [63:0] h;
      logic [NodeW-1:0] full;
      h = s.a ^ s.b ^ s.c ^ s.d;
      full = {h[NodeBits-1:0], side};
      return OutW'(full);
   endfunction

endpackage

// File: sv/geeh_lane.sv
module geeh_lane (
   input  logic                        clock,
   input  geeh_pkg::stage_en_type      stage_en,
   input  geeh_pkg::sip_state_type     key,
   input  logic [geeh_pkg::NonceW-1:0] nonce_head,
   input  logic [geeh_pkg::NonceW-1:0] nonce_inject,
   output geeh_pkg::sip_state_type     state_out
);

   geeh_pkg::sip_state_type stage_ff [geeh_pkg::Rounds];
   geeh_pkg::sip_state_type stage_in [geeh_pkg::Rounds];
   geeh_pkg::sip_state_type init_state;

   always_comb begin
      init_state = key;
      init_state.d = key.d ^ 64'(nonce_head);
   end

   always_comb begin
      stage_in[0] = geeh_pkg::mix_round(init_state);
      for (int i = 1; i < geeh_pkg::Rounds; i++) begin
         stage_in[i] = geeh_pkg::mix_round(stage_ff[i-1]);
      end
      stage_in[geeh_pkg::InjectAfter].a =
         stage_in[geeh_pkg::InjectAfter].a ^ 64'(nonce_inject);
      stage_in[geeh_pkg::InjectAfter].c =
         stage_in[geeh_pkg::InjectAfter].c ^ geeh_pkg::FinalConst;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < geeh_pkg::Rounds; i++) begin
         if (stage_en[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign state_out = stage_ff[geeh_pkg::Rounds-1];

endmodule

// File: sv/geeh_merge.sv
module geeh_merge (
   input  logic                          clock,
   input  logic                          load,
   input  geeh_pkg::sip_state_type       u_state,
   input  geeh_pkg::sip_state_type       v_state,
   output logic [2*geeh_pkg::OutW-1:0]   node_pair
);

   logic [2*geeh_pkg::OutW-1:0] pair_ff;
   logic [2*geeh_pkg::OutW-1:0] pair_in;

   always_comb begin
      pair_in = {geeh_pkg::node_id(v_state, 1'b1), geeh_pkg::node_id(u_state, 1'b0)};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pair_in;
      end
   end

   assign node_pair = pair_ff;

endmodule

// File: sv/graph_edge_endpoint_hash_core.sv
// An accepted edge passes through each lane's stage registers, then the merge output register.
// Throughput: one edge per cycle unless the output stalls; each endpoint has its own
// six-stage pipeline, one SipRound per stage, and both lanes feed one output register.
// A stalled output holds only the stages behind it that are full; empty stages still fill.
// Reset clears all valid flags and the four key words to zero.
module graph_edge_endpoint_hash_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // [14:0] edge_index, [15] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // [15:0] u_node, [31:16] v_node
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [geeh_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [63:0]                      csr_data
);

   geeh_pkg::sip_state_type key_ff;
   geeh_pkg::sip_state_type key_in;
   logic [geeh_pkg::Rounds-1:0] vld_ff;
   logic [geeh_pkg::Rounds-1:0] vld_in;
   logic [geeh_pkg::Rounds:0] rdy;
   logic rsp_vld_ff;
   logic rsp_vld_in;
   logic [geeh_pkg::EdgeW-1:0] edge_ff;
   logic [geeh_pkg::EdgeW-1:0] req_edge;
   geeh_pkg::stage_en_type stage_en;
   geeh_pkg::sip_state_type u_state;
   geeh_pkg::sip_state_type v_state;

   assign csr_ready = 1'b1;
   assign req_edge = req_tdata[geeh_pkg::EdgeW-1:0];

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            geeh_pkg::CsrKey0: key_in.a = csr_data;
            geeh_pkg::CsrKey1: key_in.b = csr_data;
            geeh_pkg::CsrKey2: key_in.c = csr_data;
            geeh_pkg::CsrKey3: key_in.d = csr_data;
            default: key_in = key_ff;
         endcase
      end
   end

   always_comb begin
      rdy[geeh_pkg::Rounds] = !rsp_vld_ff || rsp_tready;
      for (int i = geeh_pkg::Rounds - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      stage_en = rdy[geeh_pkg::Rounds-1:0];
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int i = 1; i < geeh_pkg::Rounds; i++) begin
         if (rdy[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
      rsp_vld_in = rdy[geeh_pkg::Rounds] ? vld_ff[geeh_pkg::Rounds-1] : rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         vld_ff <= vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         edge_ff <= req_edge;
      end
   end

   geeh_lane u_lane (
      .clock        (clock),
      .stage_en     (stage_en),
      .key          (key_ff),
      .nonce_head   ({req_edge, 1'b0}),
      .nonce_inject ({edge_ff, 1'b0}),
      .state_out    (u_state)
   );

   geeh_lane v_lane (
      .clock        (clock),
      .stage_en     (stage_en),
      .key          (key_ff),
      .nonce_head   ({req_edge, 1'b1}),
      .nonce_inject ({edge_ff, 1'b1}),
      .state_out    (v_state)
   );

   geeh_merge merge (
      .clock     (clock),
      .load      (rdy[geeh_pkg::Rounds]),
      .u_state   (u_state),
      .v_state   (v_state),
      .node_pair (rsp_tdata)
   );

   assign req_tready = rdy[0];
   assign rsp_tvalid = rsp_vld_ff;

   a_accept_fills_head: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("Accepted transfer did not enter the first stage.");

   a_tail_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[geeh_pkg::Rounds-1] && !rdy[geeh_pkg::Rounds]) |=> vld_ff[geeh_pkg::Rounds-1])
      else $error("Last stage dropped its item while the output was stalled.");

   a_node_sides: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] && rsp_tdata[16]))
      else $error("Node side bits are wrong.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] == 1'b0) |-> req_tready)
      else $error("Input stalled while the first stage was empty.");

endmodule
